### sv/tcce_pkg.sv
package tcce_pkg;

  // Screen geometry.
  localparam int ScrW = 80;
  localparam int ScrH = 25;
  localparam int ColW = $clog2(ScrW);
  localparam int RowW = $clog2(ScrH);

  localparam int CharW   = 8;
  localparam int ColourW = 4;
  localparam int CellW   = 16;
  localparam int TabStop = 8;

  // Configuration port.
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 7;
  localparam logic [CfgIdxW-1:0] CfgLeftMargin = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTextColour = 1'd1;
  localparam logic [ColourW-1:0] ColourReset   = 4'd15;

  // Character codes.
  localparam logic [CharW-1:0] ChBell      = 8'd7;
  localparam logic [CharW-1:0] ChBackspace = 8'd8;
  localparam logic [CharW-1:0] ChTab       = 8'd9;
  localparam logic [CharW-1:0] ChLineFeed  = 8'd10;
  localparam logic [CharW-1:0] ChFormFeed  = 8'd12;
  localparam logic [CharW-1:0] ChCarriage  = 8'd13;
  localparam logic [CharW-1:0] ChEscape    = 8'd27;
  localparam logic [CharW-1:0] ChDelete    = 8'd127;
  localparam logic [CharW-1:0] ChCaret     = 8'd94;
  localparam logic [CharW-1:0] PrintLow    = 8'd32;
  localparam logic [CharW-1:0] PrintHigh   = 8'd126;
  localparam logic [CharW-1:0] HighCtrlLow = 8'd224;
  localparam logic [CellW-1:0] BlankCell   = 16'h0020;

  // Queue between front and back.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  typedef enum logic [3:0] {
    OP_PRINT,
    OP_BS,
    OP_TAB,
    OP_LF,
    OP_FF,
    OP_CR,
    OP_NOP,
    OP_DEL,
    OP_BELL
  } tcce_op_e;

  typedef struct packed {
    tcce_op_e         op;
    logic [CharW-1:0] ch;
    logic             last;
  } tcce_entry_t;

  typedef struct packed {
    logic              write_valid;
    logic [RowW-1:0]   write_row;
    logic [ColW-1:0]   write_col;
    logic [CellW-1:0]  write_value;
    logic [RowW-1:0]   cursor_row;
    logic [ColW-1:0]   cursor_col;
    logic              scroll_up;
    logic              clear_screen;
    logic              bell;
    logic              last;
  } tcce_res_t;

  function automatic logic [RowW-1:0] next_row(input logic [RowW-1:0] r);
    next_row = (r == RowW'(ScrH - 1)) ? '0 : r + 1'b1;
  endfunction

endpackage

### sv/tcce_if.sv
interface tcce_in_if;
  logic                    valid;
  logic                    ready;
  logic [tcce_pkg::CharW-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface tcce_out_if;
  logic                         valid;
  logic                         ready;
  logic                         write_valid;
  logic [tcce_pkg::RowW-1:0]    write_row;
  logic [tcce_pkg::ColW-1:0]    write_col;
  logic [tcce_pkg::CellW-1:0]   write_value;
  logic [tcce_pkg::RowW-1:0]    cursor_row;
  logic [tcce_pkg::ColW-1:0]    cursor_col;
  logic                         scroll_up;
  logic                         clear_screen;
  logic                         bell;
  logic                         last;

  modport source (output valid, output write_valid, output write_row, output write_col,
                  output write_value, output cursor_row, output cursor_col,
                  output scroll_up, output clear_screen, output bell, output last,
                  input ready);
  modport sink (input valid, input write_valid, input write_row, input write_col,
                input write_value, input cursor_row, input cursor_col,
                input scroll_up, input clear_screen, input bell, input last,
                output ready);
endinterface

interface tcce_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tcce_pkg::CfgIdxW-1:0]  index;
  logic [tcce_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### sv/tcce_queue.sv
module tcce_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tcce_pkg::tcce_entry_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output tcce_pkg::tcce_entry_t pop_data_o,
  output logic                  empty_o
);
  import tcce_pkg::*;

  tcce_entry_t           slot_q [QDepth];
  logic [QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]        count_q;

  assign full_o     = (count_q == (QPtrW+1)'(QDepth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("queue written while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("queue read while empty");

endmodule

### sv/tcce_front.sv
module tcce_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tcce_in_if.sink               in_i,
  input  logic                  full_i,
  output logic                  push_o,
  output tcce_pkg::tcce_entry_t push_data_o
);
  import tcce_pkg::*;

  logic        pend_q, pend_d;
  tcce_entry_t pend_data_q;
  tcce_entry_t first_e, second_e;
  logic        is_caret, accept;

  // Classify the byte. Caret bytes produce a caret print now and a
  // second entry that is held until the queue has room for it.
  always_comb begin
    first_e  = '{op: OP_NOP, ch: in_i.char_code, last: 1'b1};
    second_e = '{op: OP_NOP, ch: '0, last: 1'b1};
    is_caret = 1'b0;
    unique case (in_i.char_code)
      ChBell:      first_e.op = OP_BELL;
      ChBackspace: first_e.op = OP_BS;
      ChTab:       first_e.op = OP_TAB;
      ChLineFeed:  first_e.op = OP_LF;
      ChFormFeed:  first_e.op = OP_FF;
      ChCarriage:  first_e.op = OP_CR;
      ChEscape:    first_e.op = OP_NOP;
      ChDelete:    first_e.op = OP_DEL;
      default: begin
        if (in_i.char_code >= PrintLow && in_i.char_code <= PrintHigh) begin
          first_e.op = OP_PRINT;
        end else begin
          is_caret      = 1'b1;
          first_e       = '{op: OP_PRINT, ch: ChCaret, last: 1'b0};
          if (in_i.char_code < PrintLow) begin
            second_e.op = OP_PRINT;
            second_e.ch = {3'b010, in_i.char_code[4:0]};
          end else if (in_i.char_code >= HighCtrlLow) begin
            second_e.op = OP_PRINT;
            second_e.ch = {2'b00, in_i.char_code[5:0]};
          end
        end
      end
    endcase
  end

  assign in_i.ready  = !pend_q && !full_i;
  assign accept      = in_i.valid && in_i.ready;
  assign push_o      = accept || (pend_q && !full_i);
  assign push_data_o = pend_q ? pend_data_q : first_e;

  always_comb begin
    pend_d = pend_q;
    if (pend_q && !full_i) begin
      pend_d = 1'b0;
    end else if (accept && is_caret) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_caret) pend_data_q <= second_e;
  end

endmodule

### sv/tcce_back.sv
module tcce_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tcce_cfg_if.sink              cfg_i,
  input  logic                  empty_i,
  input  tcce_pkg::tcce_entry_t entry_i,
  output logic                  pop_o,
  tcce_out_if.source            out_o
);
  import tcce_pkg::*;

  logic [RowW-1:0]    cur_row_q, cur_row_d;
  logic [ColW-1:0]    cur_col_q, cur_col_d;
  logic [ColW-1:0]    margin_q, margin;
  logic [ColourW-1:0] colour_q;
  logic               out_valid_q, out_valid_d;
  tcce_res_t          res_q, res_d;
  logic [ColW:0]      tab_stop;
  logic               advance;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= '0;
      colour_q <= ColourReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgLeftMargin: margin_q <= cfg_i.data[ColW-1:0];
        CfgTextColour: colour_q <= cfg_i.data[ColourW-1:0];
        default: ;
      endcase
    end
  end

  assign margin   = (margin_q > ColW'(ScrW - 1)) ? ColW'(ScrW - 1) : margin_q;
  assign tab_stop = ((ColW+1)'(cur_col_q) & ~(ColW+1)'(TabStop - 1)) + (ColW+1)'(TabStop);
  assign advance  = !empty_i && (!out_valid_q || out_o.ready);
  assign pop_o    = advance;

  always_comb begin
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    res_d     = '0;
    unique case (entry_i.op)
      OP_PRINT: begin
        res_d.write_valid = 1'b1;
        res_d.write_row   = cur_row_q;
        res_d.write_col   = cur_col_q;
        res_d.write_value = {4'b0000, colour_q, entry_i.ch};
        if (cur_col_q == ColW'(ScrW - 1)) begin
          cur_row_d = next_row(cur_row_q);
          cur_col_d = '0;
        end else begin
          cur_col_d = cur_col_q + 1'b1;
        end
      end
      OP_BS: cur_col_d = (cur_col_q > margin) ? cur_col_q - 1'b1 : margin;
      OP_TAB: begin
        if (tab_stop >= (ColW+1)'(ScrW)) begin
          cur_row_d = next_row(cur_row_q);
          cur_col_d = '0;
        end else begin
          cur_col_d = tab_stop[ColW-1:0];
        end
      end
      OP_LF: begin
        cur_row_d = next_row(cur_row_q);
        cur_col_d = margin;
      end
      OP_FF: begin
        res_d.clear_screen = 1'b1;
        cur_row_d = '0;
        cur_col_d = '0;
      end
      OP_CR: cur_col_d = margin;
      OP_DEL: begin
        if (cur_col_q > margin) begin
          cur_col_d         = cur_col_q - 1'b1;
          res_d.write_valid = 1'b1;
          res_d.write_row   = cur_row_q;
          res_d.write_col   = cur_col_q - 1'b1;
          res_d.write_value = BlankCell;
        end
      end
      OP_BELL: res_d.bell = 1'b1;
      default: ;
    endcase
    // Reaching the bottom row scrolls the screen.
    if (cur_row_d == RowW'(ScrH - 1)) begin
      res_d.scroll_up = 1'b1;
      cur_row_d = RowW'(ScrH - 2);
      cur_col_d = '0;
    end
    res_d.cursor_row = cur_row_d;
    res_d.cursor_col = cur_col_d;
    res_d.last       = entry_i.last;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        cur_row_q <= cur_row_d;
        cur_col_q <= cur_col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.write_valid  = res_q.write_valid;
  assign out_o.write_row    = res_q.write_row;
  assign out_o.write_col    = res_q.write_col;
  assign out_o.write_value  = res_q.write_value;
  assign out_o.cursor_row   = res_q.cursor_row;
  assign out_o.cursor_col   = res_q.cursor_col;
  assign out_o.scroll_up    = res_q.scroll_up;
  assign out_o.clear_screen = res_q.clear_screen;
  assign out_o.bell         = res_q.bell;
  assign out_o.last         = res_q.last;

  assert property (@(posedge clk_i) disable iff (!rst_ni) cur_row_q != RowW'(ScrH - 1))
    else $error("cursor left on the bottom row");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cur_col_q < ColW'(ScrW))
    else $error("cursor column beyond the screen");

endmodule

### sv/text_console_char_engine_core.sv
// Channel   Direction  Payload                                        Accepted when
// in_i      sink       char_code                                      valid && ready
// out_o     source     write_valid/row/col/value, cursor_row/col,     valid && ready
//                      scroll_up, clear_screen, bell, last
// cfg_i     sink       index (0 left_margin, 1 text_colour), data     valid && ready
//
// One byte enters per cycle while the queue has room and no second entry waits. A caret byte
// (control or high byte without its own handling) gives two results and holds in_i.ready low
// while its second entry waits. An accepted byte passes through the queue and the result
// register before its first result transaction. Reset is asynchronous and active low; cfg_i
// is always ready. A stall on out_o fills the four-entry queue and only then stops input.
module text_console_char_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcce_in_if.sink     in_i,
  tcce_out_if.source  out_o,
  tcce_cfg_if.sink    cfg_i
);
  import tcce_pkg::*;

  // The front end decodes each byte into a cursor operation and splits caret
  // bytes into two operations. The queue decouples it from the back end, which
  // owns the cursor and configuration registers and registers each result.
  logic        push, full, pop, empty;
  tcce_entry_t push_data, pop_data;

  tcce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  tcce_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  tcce_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .empty_i (empty),
    .entry_i (pop_data),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the text console character engine.
module tb;
  import tcce_pkg::*;

  // A control byte shown with a caret prints its letter form, byte + 64 taken
  // modulo 256. This covers both 0..31 and the high bytes 224..255.
  localparam logic [CharW-1:0] CtrlOffset = 8'd64;

  // Scoreboard: tracks the cursor and the configuration on its own and keeps
  // the results that the engine still owes, oldest first.
  class console_scoreboard;
    int unsigned cur_row;
    int unsigned cur_col;
    int unsigned margin;
    int unsigned colour;
    tcce_res_t   pending_results[$];
    int unsigned mismatches;
    int unsigned n_chars;
    int unsigned n_results;
    int unsigned n_scrolls;
    int unsigned n_carets;

    function new();
      cur_row     = 0;
      cur_col     = 0;
      margin      = 0;
      colour      = ColourReset;
      mismatches  = 0;
      n_chars     = 0;
      n_results   = 0;
      n_scrolls   = 0;
      n_carets    = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgLeftMargin: margin = data;
        CfgTextColour: colour = data[ColourW-1:0];
        default: ;
      endcase
    endfunction

    function void step_row();
      cur_row = (cur_row + 1) % ScrH;
    endfunction

    // Applies one byte without caret expansion and returns the result that
    // it produces, including the bottom-row scroll.
    function tcce_res_t render_code(logic [CharW-1:0] code, bit act, bit is_last);
      tcce_res_t   r;
      int unsigned m;
      int unsigned stop;
      r = '0;
      m = (margin > ScrW - 1) ? ScrW - 1 : margin;
      if (act) begin
        case (code)
          ChBell: r.bell = 1'b1;
          ChBackspace: cur_col = (cur_col > m) ? cur_col - 1 : m;
          ChTab: begin
            stop = (cur_col / TabStop + 1) * TabStop;
            if (stop >= ScrW) begin
              step_row();
              cur_col = 0;
            end else begin
              cur_col = stop;
            end
          end
          ChLineFeed: begin
            step_row();
            cur_col = m;
          end
          ChFormFeed: begin
            r.clear_screen = 1'b1;
            cur_row = 0;
            cur_col = 0;
          end
          ChCarriage: cur_col = m;
          ChEscape: ;
          ChDelete: begin
            if (cur_col > m) begin
              cur_col       = cur_col - 1;
              r.write_valid = 1'b1;
              r.write_row   = RowW'(cur_row);
              r.write_col   = ColW'(cur_col);
              r.write_value = BlankCell;
            end
          end
          default: begin
            if (code >= PrintLow && code <= PrintHigh) begin
              r.write_valid = 1'b1;
              r.write_row   = RowW'(cur_row);
              r.write_col   = ColW'(cur_col);
              r.write_value = {4'd0, ColourW'(colour), code};
              if (cur_col + 1 >= ScrW) begin
                step_row();
                cur_col = 0;
              end else begin
                cur_col = cur_col + 1;
              end
            end
          end
        endcase
      end
      // Landing on the bottom row scrolls the screen and pulls the cursor
      // back to the start of the row above.
      if (cur_row == ScrH - 1) begin
        r.scroll_up = 1'b1;
        cur_row     = ScrH - 2;
        cur_col     = 0;
        n_scrolls++;
      end
      r.cursor_row = RowW'(cur_row);
      r.cursor_col = ColW'(cur_col);
      r.last       = is_last;
      return r;
    endfunction

    // Called for each accepted input transaction.
    function void note_char(logic [CharW-1:0] b);
      bit named;
      if (cur_row >= ScrH) cur_row = ScrH - 1;
      if (cur_col >= ScrW) cur_col = ScrW - 1;
      named = b inside {ChBell, ChBackspace, ChTab, ChLineFeed, ChFormFeed,
                        ChCarriage, ChEscape, ChDelete};
      n_chars++;
      if (!named && (b < PrintLow || b[CharW-1])) begin
        // Caret first, then the letter form. Bytes 128..223 have no
        // printable letter form, so the second result only repeats the cursor.
        n_carets++;
        pending_results.push_back(render_code(ChCaret, 1'b1, 1'b0));
        if (b < PrintLow || b >= HighCtrlLow) begin
          pending_results.push_back(render_code(b + CtrlOffset, 1'b1, 1'b1));
        end else begin
          pending_results.push_back(render_code('0, 1'b0, 1'b1));
        end
      end else begin
        pending_results.push_back(render_code(b, 1'b1, 1'b1));
      end
    endfunction

    function void compare_field(string what, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, what, exp_v, act_v);
      end
    endfunction

    // Called for each accepted output transaction.
    function void check_result(tcce_res_t act);
      tcce_res_t exp_r;
      n_results++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending, expected none actual cursor %0d,%0d",
                 $time, act.cursor_row, act.cursor_col);
        return;
      end
      exp_r = pending_results.pop_front();
      compare_field("write_valid", exp_r.write_valid, act.write_valid);
      compare_field("write_row", exp_r.write_row, act.write_row);
      compare_field("write_col", exp_r.write_col, act.write_col);
      compare_field("write_value", exp_r.write_value, act.write_value);
      compare_field("cursor_row", exp_r.cursor_row, act.cursor_row);
      compare_field("cursor_col", exp_r.cursor_col, act.cursor_col);
      compare_field("scroll_up", exp_r.scroll_up, act.scroll_up);
      compare_field("clear_screen", exp_r.clear_screen, act.clear_screen);
      compare_field("bell", exp_r.bell, act.bell);
      compare_field("last", exp_r.last, act.last);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  tcce_in_if  in_if ();
  tcce_out_if out_if ();
  tcce_cfg_if cfg_if ();

  text_console_char_engine_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  console_scoreboard board = new();

  // Idling percentages for the current phase, sender and receiver side.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Every input starts at a known value while reset is held low.
  initial begin
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.char_code <= '0;
    out_if.ready   <= 1'b0;
    cfg_if.valid   <= 1'b0;
    cfg_if.index   <= '0;
    cfg_if.data    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver. Handshake signals are sampled right after the edge, before any
  // nonblocking update of this step, so they hold the values the flops saw.
  initial begin
    tcce_res_t got;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.write_valid  = out_if.write_valid;
        got.write_row    = out_if.write_row;
        got.write_col    = out_if.write_col;
        got.write_value  = out_if.write_value;
        got.cursor_row   = out_if.cursor_row;
        got.cursor_col   = out_if.cursor_col;
        got.scroll_up    = out_if.scroll_up;
        got.clear_screen = out_if.clear_screen;
        got.bell         = out_if.bell;
        got.last         = out_if.last;
        board.check_result(got);
      end
      out_if.ready <= ($urandom_range(99) < rx_stall_pct) ? 1'b0 : 1'b1;
    end
  end

  // Sends one byte. Random idle cycles come first; when there are none, valid
  // simply stays high from the previous transaction.
  task automatic send_char(input logic [CharW-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    board.note_char(b);
  endtask

  // Stops the sender and waits until every expected result has arrived, then
  // lets the number of further cycles given by extra pass.
  task automatic wait_drained(input int unsigned extra);
    in_if.valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Writes both registers back to back; valid stays high between them.
  task automatic write_config(input logic [CfgDataW-1:0] margin_v,
                              input logic [ColourW-1:0] colour_v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CfgLeftMargin;
    cfg_if.data  <= margin_v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    board.set_reg(CfgLeftMargin, margin_v);
    cfg_if.index <= CfgTextColour;
    cfg_if.data  <= CfgDataW'(colour_v);
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    board.set_reg(CfgTextColour, CfgDataW'(colour_v));
    cfg_if.valid <= 1'b0;
  endtask

  // Random byte mix. Printable text dominates, with plenty of line feeds so
  // that the cursor reaches the bottom row and scrolling is exercised. Form
  // feed only shows up through the rare buckets, so the screen seldom resets.
  function automatic logic [CharW-1:0] pick_char();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45)      return CharW'($urandom_range(PrintHigh, PrintLow));
    else if (sel < 58) return ChLineFeed;
    else if (sel < 63) return ChCarriage;
    else if (sel < 69) return ChBackspace;
    else if (sel < 75) return ChTab;
    else if (sel < 81) return ChDelete;
    else if (sel < 83) return ChBell;
    else if (sel < 85) return ChEscape;
    else if (sel < 90) return CharW'($urandom_range(31, 0));
    else if (sel < 98) return CharW'($urandom_range(255, 128));
    else               return CharW'($urandom_range(255, 0));
  endfunction

  // Directed bytes: both ends of the printable range, delete with and without
  // a character to erase, each named control, both ends of the caret ranges
  // and the high bytes that have no letter form.
  logic [CharW-1:0] directed_chars[] = '{
    8'h41, PrintLow, PrintHigh, ChDelete, ChBackspace, ChBackspace, ChTab,
    ChCarriage, ChDelete, ChLineFeed, ChBell, ChEscape, 8'd0, 8'd31, 8'd1,
    8'd128, 8'd223, HighCtrlLow, 8'd255, ChFormFeed, ChBackspace, ChDelete
  };

  // Margin and colour per phase: a margin past the screen edge, the largest
  // raw value, the last usable column and both colour extremes.
  logic [CfgDataW-1:0] phase_margin[8] = '{7'd80, 7'd127, 7'd0, 7'd0,
                                           7'd79, 7'd0, 7'd8, 7'd0};
  logic [ColourW-1:0]  phase_colour[8] = '{4'd0, 4'd15, 4'd7, 4'd0,
                                           4'd1, 4'd0, 4'd0, 4'd15};

  localparam int NumPhases = 9;
  localparam int PhaseItems = 52;

  initial begin
    logic [CfgDataW-1:0] m_v;
    logic [ColourW-1:0]  c_v;
    @(posedge rst_ni);
    @(posedge clk_i);

    for (int p = 0; p < NumPhases; p++) begin
      // Registers change only while the engine is idle.
      if (p > 0) begin
        wait_drained(6);
        m_v = phase_margin[p-1];
        c_v = phase_colour[p-1];
        if (p == 4 || p == 6) begin
          m_v = CfgDataW'($urandom_range(127, 0));
          c_v = ColourW'($urandom_range(15, 0));
        end
        if (p == 7) c_v = ColourW'($urandom_range(15, 0));
        write_config(m_v, c_v);
      end

      // Idling modes rotate: none, sender, receiver, both.
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 49; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 49; end
        default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
      endcase

      if (p == 0) begin
        foreach (directed_chars[i]) send_char(directed_chars[i]);
      end

      for (int i = 0; i < ((p == 0) ? 30 : PhaseItems); i++) begin
        // At item PhaseItems / 2, the sender holds off until the engine has
        // delivered everything, so the queue runs empty mid-stream.
        if (i == PhaseItems / 2) wait_drained(0);
        send_char(pick_char());
      end
    end

    wait_drained(10);

    $display("Sent %0d bytes (%0d caret pairs), checked %0d results, %0d scrolls,",
             board.n_chars, board.n_carets, board.n_results, board.n_scrolls);
    $display("over %0d phases of margin and colour settings and all idling modes.",
             NumPhases);
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Timeout with %0d results still pending", board.pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
